@@ hw/rtl/aswp_pkg.sv @@
// ----------------------------------------------------------------------------
// aswp_pkg
// Shared types for the argsort block: request and result payloads, and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aswp_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned IdxW = 6;

  // Configuration register indexes
  localparam logic CfgReportOrder = 1'b0;
  localparam logic CfgSignedKeys  = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            last_key;
  } req_t;

  typedef struct packed {
    logic [KeyW-1:0] sorted_key;
    logic [IdxW-1:0] source_index;
    logic            last_result;
    logic            overflow;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch request, pointer <= count
    logic start_read;  // read entry ptr-1
    logic cmp_read;    // read entry ptr-2
    logic write_shift; // entry ptr <= read data
    logic write_new;   // entry ptr <= new key, count++
    logic dec_ptr;
    logic set_ovf;
    logic emit_read;   // read entry at emit pointer, advance it
    logic clear;       // end of set
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic ptr_one;
    logic greater;     // stored key orders after the new key
    logic last;
    logic emit_end;
  } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/aswp_ctrl.sv @@
// ----------------------------------------------------------------------------
// aswp_ctrl
// Sequencer for insertion and emission of one key set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aswp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire aswp_pkg::status_t status_i,
  output aswp_pkg::cmd_t         cmd_o,
  output logic                   busy_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StStart = 3'd1;
  localparam logic [2:0] StCmp   = 3'd2;
  localparam logic [2:0] StPlace = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StStart;
        end
      end
      StStart: begin
        if (status_i.cnt_full) begin
          cmd_o.set_ovf = 1'b1;
          state_d       = status_i.last ? StEmit : StIdle;
        end else if (status_i.cnt_zero) begin
          cmd_o.write_new = 1'b1;
          state_d         = status_i.last ? StEmit : StIdle;
        end else begin
          cmd_o.start_read = 1'b1;
          state_d          = StCmp;
        end
      end
      StCmp: begin
        if (status_i.greater) begin
          cmd_o.write_shift = 1'b1;
          cmd_o.dec_ptr     = 1'b1;
          if (status_i.ptr_one) begin
            state_d = StPlace;
          end else begin
            cmd_o.cmp_read = 1'b1;
          end
        end else begin
          cmd_o.write_new = 1'b1;
          state_d         = status_i.last ? StEmit : StIdle;
        end
      end
      StPlace: begin
        cmd_o.write_new = 1'b1;
        state_d         = status_i.last ? StEmit : StIdle;
      end
      StEmit: begin
        cmd_o.emit_read = 1'b1;
        if (status_i.emit_end) begin
          cmd_o.clear = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy_o = (state_q != StIdle);

endmodule

`default_nettype wire

@@ hw/rtl/aswp_datapath.sv @@
// ----------------------------------------------------------------------------
// aswp_datapath
// Key/index memories, insertion pointer, compare and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aswp_datapath #(
  parameter int unsigned MAX_KEYS = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire aswp_pkg::cmd_t    cmd_i,
  input  wire aswp_pkg::req_t    req_i,
  input  wire logic              signed_keys_i,
  input  wire logic              report_order_i,
  output aswp_pkg::status_t      status_o,
  output logic                   result_valid_o,
  output aswp_pkg::result_t      result_o
);

  localparam int unsigned CW = $clog2(MAX_KEYS + 1);
  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned IW = aswp_pkg::IdxW;

  logic [KEY_BITS-1:0] key_mem [MAX_KEYS];
  logic [IW-1:0]       idx_mem [MAX_KEYS];

  logic [KEY_BITS-1:0] new_key_q;
  logic                last_q;
  logic [CW-1:0]       cnt_q, ptr_q, eptr_q;
  logic                ovf_q;
  logic [KEY_BITS-1:0] key_rd_q;
  logic [IW-1:0]       idx_rd_q;
  logic                out_valid_q, out_last_q, out_ovf_q;

  logic [CW-1:0]       ptr_m1, ptr_m2, cnt_m1;
  logic [KEY_BITS-1:0] sign_flip;
  logic                mem_we, mem_re;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [KEY_BITS-1:0] wr_key;
  logic [IW-1:0]       wr_idx;

  assign ptr_m1    = ptr_q - CW'(1);
  assign ptr_m2    = ptr_q - CW'(2);
  assign cnt_m1    = cnt_q - CW'(1);
  assign sign_flip = {signed_keys_i, {(KEY_BITS-1){1'b0}}};

  // write port
  assign mem_we  = cmd_i.write_shift | cmd_i.write_new;
  assign wr_addr = ptr_q[AW-1:0];
  assign wr_key  = cmd_i.write_shift ? key_rd_q : new_key_q;
  assign wr_idx  = cmd_i.write_shift ? idx_rd_q : IW'(cnt_q);

  // read port
  assign mem_re = cmd_i.start_read | cmd_i.cmp_read | cmd_i.emit_read;
  always_comb begin
    rd_addr = eptr_q[AW-1:0];
    if (cmd_i.start_read) begin
      rd_addr = ptr_m1[AW-1:0];
    end else if (cmd_i.cmp_read) begin
      rd_addr = ptr_m2[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[wr_addr] <= wr_key;
      idx_mem[wr_addr] <= wr_idx;
    end
    if (mem_re) begin
      key_rd_q <= key_mem[rd_addr];
      idx_rd_q <= idx_mem[rd_addr];
    end
    if (cmd_i.load) begin
      new_key_q <= KEY_BITS'(req_i.key);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= 1'b0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      eptr_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit_read;
      out_last_q  <= cmd_i.emit_read & status_o.emit_end;
      out_ovf_q   <= ovf_q;
      if (cmd_i.load) begin
        last_q <= req_i.last_key;
        ptr_q  <= cnt_q;
      end else if (cmd_i.dec_ptr) begin
        ptr_q <= ptr_m1;
      end
      if (cmd_i.clear) begin
        cnt_q  <= '0;
        ovf_q  <= 1'b0;
        eptr_q <= '0;
      end else begin
        if (cmd_i.emit_read) begin
          eptr_q <= eptr_q + CW'(1);
        end
        if (cmd_i.write_new) begin
          cnt_q <= cnt_q + CW'(1);
        end
        if (cmd_i.set_ovf) begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.cnt_full = (cnt_q == CW'(MAX_KEYS));
  assign status_o.ptr_one  = (ptr_q == CW'(1));
  assign status_o.greater  = ((key_rd_q ^ sign_flip) > (new_key_q ^ sign_flip));
  assign status_o.last     = last_q;
  assign status_o.emit_end = (eptr_q == cnt_m1);

  assign result_valid_o        = out_valid_q;
  assign result_o.sorted_key   = aswp_pkg::KeyW'(key_rd_q);
  assign result_o.source_index = idx_rd_q & {IW{report_order_i}};
  assign result_o.last_result  = out_last_q;
  assign result_o.overflow     = out_ovf_q;

endmodule

`default_nettype wire

@@ hw/rtl/argsort_with_permutation.sv @@
// ----------------------------------------------------------------------------
// argsort_with_permutation
// Stable ascending argsort: keys load one per request, sorted keys leave with
// their original load positions (0 if report_order is 0) after the last key.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a key is taken at a rising edge with start_i high and
//   busy_o low. req_i.last_key closes the set.
//   Each key is placed by an insertion walk over one memory port pair: a
//   look at the tail, then one step per stored key that orders after the
//   new one, plus one step to place it. busy_o stays high for the whole
//   walk; a key into an empty set, or one dropped because the set is full,
//   is written or dropped without a walk.
//   After the closing key is placed or dropped, n stored keys are read out
//   one per cycle through the registered read port; each result sits on
//   result_o for one cycle with result_valid_o high, first result in the
//   cycle after the read starts. busy_o drops after the last read, so a new
//   set may start while the last result is shown.
//   The receiver takes every result as it appears; there is no back-pressure.
//   Keys beyond MAX_KEYS are dropped and flag overflow on every result of
//   that set. Equal keys keep arrival order.
//   Configuration: cfg_we_i writes bit 0 of cfg_wdata_i to cfg_index_i (0:
//   report_order, 1: signed_keys); users write only while idle, not enforced.
//   Reset: empty set, report_order = 1, signed_keys = 0; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module argsort_with_permutation #(
  parameter int unsigned MAX_KEYS = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request channel
  input  wire logic              start_i,
  input  wire aswp_pkg::req_t    req_i,
  output logic                   busy_o,
  // result channel
  output logic                   result_valid_o,
  output aswp_pkg::result_t      result_o,
  // configuration write port
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic              cfg_wdata_i
);

  aswp_pkg::cmd_t    cmd;
  aswp_pkg::status_t status;

  logic report_order_q, signed_keys_q;

  // Set-once style registers; user writes only while idle, not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_order_q <= 1'b1;
      signed_keys_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        aswp_pkg::CfgReportOrder: report_order_q <= cfg_wdata_i;
        aswp_pkg::CfgSignedKeys:  signed_keys_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  aswp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Compare uses the live signed_keys value at each insertion.
  aswp_datapath #(
    .MAX_KEYS (MAX_KEYS),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_i          (req_i),
    .signed_keys_i  (signed_keys_q),
    .report_order_i (report_order_q),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire
